>>> rtl/core/urf_pkg.sv
// shared constants, types and pointer helpers for the uart receive ring
`default_nettype none
package urf_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int DATA_W     = 8;
   localparam int ERR_W      = 4;
   localparam int FILL_W     = 10;
   localparam int OVF_W      = 16;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [ERR_W-1:0]  err_type;
   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [OVF_W-1:0]  ovf_type;

   typedef struct packed {
      logic     rd_valid;
      logic     stored;
      logic     dropped;
      logic     spurious;
      err_type  line_errs;
      fill_type fill_level;
      ovf_type  overflow_total;
   } urf_status_type;

   function automatic ptr_type ring_adv(input ptr_type p);
      ptr_type nxt;
      begin
         nxt = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
         return nxt;
      end
   endfunction

   function automatic ptr_type ring_fill(input ptr_type wp, input ptr_type rp);
      ptr_type f;
      begin
         f = (wp >= rp) ? (wp - rp) : (wp - rp + PTR_W'(RING_DEPTH));
         return f;
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/urf_ram.sv
// generic single-write, single-read synchronous ram with registered read
`default_nettype none
module urf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/urf_ptr.sv
// ring pointers, overflow counter and per-transaction status
`default_nettype none
module urf_ptr
   import urf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_accept,
   input  wire logic     op,
   input  wire logic     rx_ready,
   input  wire err_type  errs,
   output logic          ram_wr_en,
   output ptr_type       ram_wr_addr,
   output logic          ram_rd_en,
   output ptr_type       ram_rd_addr,
   output urf_status_type status
);

   ptr_type wp_ff, wp_in;
   ptr_type rp_ff, rp_in;
   ovf_type ovf_ff, ovf_in;

   ptr_type wp_adv;
   logic    not_empty;
   logic    full;
   logic    do_read;
   logic    do_store;

   always_comb begin
      wp_adv    = ring_adv(wp_ff);
      not_empty = (rp_ff != wp_ff);
      full      = (wp_adv == rp_ff);
      do_read   = (op == OP_READ) && not_empty;
      do_store  = (op == OP_RECEIVE) && rx_ready;

      wp_in  = wp_ff;
      rp_in  = rp_ff;
      ovf_in = ovf_ff;
      if (do_read) begin
         rp_in = ring_adv(rp_ff);
      end
      if (do_store) begin
         wp_in = wp_adv;
         if (full) begin
            rp_in  = ring_adv(rp_ff);
            ovf_in = ovf_ff + 1'b1;
         end
      end

      status.rd_valid       = do_read;
      status.stored         = do_store;
      status.dropped        = do_store && full;
      status.spurious       = (op == OP_RECEIVE) && !rx_ready && (errs == '0);
      status.line_errs      = (op == OP_RECEIVE) ? errs : '0;
      status.fill_level     = FILL_W'(ring_fill(wp_in, rp_in));
      status.overflow_total = ovf_in;

      ram_wr_en   = item_accept && do_store;
      ram_wr_addr = wp_ff;
      ram_rd_en   = item_accept && do_read;
      ram_rd_addr = rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         ovf_ff <= '0;
      end else if (item_accept) begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         ovf_ff <= ovf_in;
      end
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !item_accept |=> $stable(wp_ff) && $stable(rp_ff) && $stable(ovf_ff))
      else $error("ring state moved without a transaction");

   a_drop_counts: assert property (@(posedge clock) disable iff (reset)
      item_accept && status.dropped |=> ovf_ff == OVF_W'($past(ovf_ff) + 1'b1))
      else $error("overflow counter missed a dropped byte");

   a_drop_needs_store: assert property (@(posedge clock) disable iff (reset)
      status.dropped |-> status.stored && !status.rd_valid)
      else $error("drop without a store");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(wp_ff) < RING_DEPTH) && (32'(rp_ff) < RING_DEPTH))
      else $error("ring pointer out of range");

endmodule
`default_nettype wire

>>> rtl/core/uart_rx_ring_fifo_drop_oldest.sv
// top level: uart receive ring buffer with drop-oldest overflow
//
//  channel | ports                | transaction
//  --------+----------------------+-----------------------------------------
//  request | req_valid/req_ready  | receive event or software read
//  result  | rsp_valid/rsp_ready  | one status and data word per request
//
//  one transaction per cycle while the result channel is not stalled; a
//  request's result is registered in the middle stage, beside the registered
//  read of the byte store, and then in the output register.
//  reset clears the pointers, the overflow counter and both pipeline valids;
//  the byte store is not cleared.
//  a stalled result holds the middle stage, which then blocks new requests.
`default_nettype none
module uart_rx_ring_fifo_drop_oldest
   import urf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic     req_op,
   input  wire logic     req_rx_ready,
   input  wire logic     req_overrun_err,
   input  wire logic     req_noise_err,
   input  wire logic     req_framing_err,
   input  wire logic     req_parity_err,
   input  wire data_type req_rx_byte,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output logic          rsp_read_valid,
   output data_type      rsp_read_data,
   output logic          rsp_stored,
   output logic          rsp_dropped_oldest,
   output logic          rsp_spurious,
   output err_type       rsp_line_errs,
   output fill_type      rsp_fill_level,
   output ovf_type       rsp_overflow_total
);

   logic           item_accept;
   logic           ram_wr_en;
   logic           ram_rd_en;
   ptr_type        ram_wr_addr;
   ptr_type        ram_rd_addr;
   data_type       ram_rd_data;
   urf_status_type status;
   err_type        errs;

   logic           mid_valid_ff, mid_valid_in;
   urf_status_type mid_status_ff;
   logic           out_valid_ff, out_valid_in;
   urf_status_type out_status_ff;
   data_type       out_data_ff;
   logic           mid_advance;

   assign errs        = {req_parity_err, req_framing_err, req_noise_err, req_overrun_err};
   assign mid_advance = mid_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !mid_valid_ff || mid_advance;
   assign item_accept = req_valid && req_ready;

   urf_ptr u_ptr (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .op          (req_op),
      .rx_ready    (req_rx_ready),
      .errs        (errs),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .status      (status)
   );

   urf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RING_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      mid_valid_in = item_accept || (mid_valid_ff && !mid_advance);
      out_valid_in = mid_advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         mid_status_ff <= status;
      end
      if (mid_advance) begin
         out_status_ff <= mid_status_ff;
         out_data_ff   <= mid_status_ff.rd_valid ? ram_rd_data : '0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_valid     = out_status_ff.rd_valid;
   assign rsp_read_data      = out_data_ff;
   assign rsp_stored         = out_status_ff.stored;
   assign rsp_dropped_oldest = out_status_ff.dropped;
   assign rsp_spurious       = out_status_ff.spurious;
   assign rsp_line_errs      = out_status_ff.line_errs;
   assign rsp_fill_level     = out_status_ff.fill_level;
   assign rsp_overflow_total = out_status_ff.overflow_total;

   a_read_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en || ram_wr_en) |-> item_accept)
      else $error("store accessed without a transaction");

   a_mid_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && out_valid_ff && !rsp_ready |=> mid_valid_ff && $stable(mid_status_ff))
      else $error("middle stage lost a transaction under stall");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline blocked");

endmodule
`default_nettype wire
